// ===== hdl/smx_pkg.sv =====
// Package for the softmax normalizer: widths, constants, exponent table.
// No dependencies.
package smx_pkg;
	localparam int MAX_LEN_DEF = 64;
	localparam int VAL_W = 16;
	localparam int EXP_W = 17;
	localparam int SUM_W = 23;
	localparam int IDX_W = 6;
	localparam logic [14:0] LOG2E_Q14 = 15'd23637;

	function automatic logic [16:0] pow2_tab(input logic [4:0] k);
		case (k)
			5'd0: pow2_tab = 17'd65536;
			5'd1: pow2_tab = 17'd62757;
			5'd2: pow2_tab = 17'd60097;
			5'd3: pow2_tab = 17'd57549;
			5'd4: pow2_tab = 17'd55109;
			5'd5: pow2_tab = 17'd52773;
			5'd6: pow2_tab = 17'd50535;
			5'd7: pow2_tab = 17'd48393;
			5'd8: pow2_tab = 17'd46341;
			5'd9: pow2_tab = 17'd44376;
			5'd10: pow2_tab = 17'd42495;
			5'd11: pow2_tab = 17'd40693;
			5'd12: pow2_tab = 17'd38968;
			5'd13: pow2_tab = 17'd37316;
			5'd14: pow2_tab = 17'd35734;
			5'd15: pow2_tab = 17'd34219;
			5'd16: pow2_tab = 17'd32768;
			default: pow2_tab = 17'd0;
		endcase
	endfunction
endpackage

// ===== hdl/smx_if.sv =====
// Valid/ready channel interfaces for the softmax normalizer.
// No dependencies.
interface smx_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample_value;
	logic sample_last;
	modport source (output valid, sample_value, sample_last, input ready);
	modport sink (input valid, sample_value, sample_last, output ready);
endinterface

interface smx_out_if;
	logic valid;
	logic ready;
	logic [15:0] prob_value;
	logic [5:0] elem_index;
	logic result_last;
	logic overflow_flag;
	modport source (output valid, prob_value, elem_index, result_last, overflow_flag,
		input ready);
	modport sink (input valid, prob_value, elem_index, result_last, overflow_flag,
		output ready);
endinterface

interface smx_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/smx_div.sv =====
// Restoring divider, one quotient bit per cycle: q = num / den.
// No dependencies.
module smx_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [39:0] num,
	input logic [22:0] den,
	output logic done,
	output logic [39:0] quot
);
	logic [39:0] q_q;
	logic [23:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [23:0] trial;

	assign trial = {rem_q[22:0], q_q[39]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

// ===== hdl/softmax_normalizer_unit.sv =====
// Channel     | dir | payload
// in          | in  | sample_value (s16 Q4.12), sample_last
// out         | out | prob_value (u16 Q0.16), elem_index, result_last, overflow_flag
// cfg         | in  | derivative_mode (1 bit)
// Loading accepts one word per cycle. On the last word the exponent pass runs per
// element (store read, multiply, table/round), then per element: store read, divider
// start, the wait on the bit-serial divider, derivative multiply, output.
// Input not ready until the last result is loaded; a stalled output holds the register
// and the sequencer waits in the output state. Reset clears control state only.
module softmax_normalizer_unit #(
	parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	smx_in_if.sink in_ch,
	smx_out_if.source out_ch,
	smx_cfg_if.sink cfg
);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [16:0] LOG2E_Q14_U = {2'b00, smx_pkg::LOG2E_Q14};

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_ERD = 4'd1;
	localparam logic [3:0] ST_EMUL = 4'd2;
	localparam logic [3:0] ST_ECALC = 4'd3;
	localparam logic [3:0] ST_PRD = 4'd4;
	localparam logic [3:0] ST_PDIV = 4'd5;
	localparam logic [3:0] ST_PWAIT = 4'd6;
	localparam logic [3:0] ST_PDER = 4'd7;
	localparam logic [3:0] ST_POUT = 4'd8;

	logic [3:0] state_q;
	logic mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] i_q;
	logic signed [15:0] max_q;
	logic [22:0] sum_q;
	logic drop_q;
	logic [15:0] logit_mem [MAX_LEN];
	logic [16:0] exp_mem [MAX_LEN];
	logic [15:0] logit_rd_q;
	logic [16:0] exp_rd_q;
	logic [31:0] prod_q;
	logic [15:0] p_q;
	logic [15:0] prob_q;
	logic oval_q, olast_q;
	logic [5:0] oidx_q;
	logic drop_q_o;
	logic div_start, div_done;
	logic [39:0] div_quot;
	logic acc;

	assign in_ch.ready = (state_q == ST_LOAD);
	assign cfg.ready = 1'b1;
	assign acc = in_ch.valid && in_ch.ready;

	// exponent datapath from registered product d*LOG2E
	logic [16:0] e_val;
	always_comb begin
		logic [17:0] t;
		logic [5:0] n;
		logic [3:0] k;
		logic [7:0] r;
		logic [16:0] ta, tb, v;
		logic [25:0] dr;
		logic [17:0] vr;
		vr = '0;
		t = 18'((prod_q + 32'd8192) >> 14);
		n = t[17:12];
		k = t[11:8];
		r = t[7:0];
		ta = smx_pkg::pow2_tab({1'b0, k});
		tb = smx_pkg::pow2_tab({1'b0, k} + 5'd1);
		dr = 26'((ta - tb) * r) + 26'd128;
		v = ta - 17'(dr >> 8);
		if (n == 6'd0) e_val = v;
		else if (n > 6'd16) e_val = '0;
		else begin
			vr = {1'b0, v} + (18'd1 << (n - 6'd1));
			e_val = 17'(vr >> n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			mode_q <= 1'b0;
			cnt_q <= '0;
			i_q <= '0;
			max_q <= 16'sh8000;
			sum_q <= '0;
			drop_q <= 1'b0;
			oval_q <= 1'b0;
		end else begin
			if (cfg.valid) mode_q <= cfg.data;
			if (state_q == ST_POUT && (!oval_q || out_ch.ready)) oval_q <= 1'b1;
			else if (oval_q && out_ch.ready) oval_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (cnt_q < CNT_W'(MAX_LEN)) begin
							cnt_q <= cnt_q + 1'b1;
							if (in_ch.sample_value > max_q) max_q <= in_ch.sample_value;
						end else drop_q <= 1'b1;
						if (in_ch.sample_last) begin
							i_q <= '0;
							sum_q <= '0;
							if (cnt_q < CNT_W'(MAX_LEN) || cnt_q != '0)
								state_q <= ST_ERD;
							else state_q <= ST_LOAD;
						end
					end
				end
				ST_ERD: state_q <= ST_EMUL;
				ST_EMUL: state_q <= ST_ECALC;
				ST_ECALC: begin
					sum_q <= sum_q + 23'(e_val);
					if (i_q + 1'b1 == cnt_q) begin
						i_q <= '0;
						state_q <= ST_PRD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_ERD;
					end
				end
				ST_PRD: state_q <= ST_PDIV;
				ST_PDIV: state_q <= ST_PWAIT;
				ST_PWAIT: if (div_done) state_q <= ST_PDER;
				ST_PDER: state_q <= ST_POUT;
				ST_POUT: begin
					if (!oval_q || out_ch.ready) begin
						if (i_q + 1'b1 == cnt_q) begin
							state_q <= ST_LOAD;
							cnt_q <= '0;
							max_q <= 16'sh8000;
							drop_q <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_PRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign div_start = (state_q == ST_PDIV);

	smx_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({7'd0, exp_rd_q, 16'd0} + {18'd0, sum_q[22:1]}),
		.den(sum_q), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk) begin
		if (acc && cnt_q < CNT_W'(MAX_LEN)) logit_mem[cnt_q[AW-1:0]] <= in_ch.sample_value;
		if (state_q == ST_ERD) logit_rd_q <= logit_mem[i_q[AW-1:0]];
		if (state_q == ST_EMUL)
			prod_q <= 32'(17'(max_q - $signed(logit_rd_q)) * LOG2E_Q14_U);
		if (state_q == ST_ECALC) exp_mem[i_q[AW-1:0]] <= e_val;
		if (state_q == ST_PRD) exp_rd_q <= exp_mem[i_q[AW-1:0]];
		if (state_q == ST_PWAIT && div_done) begin
			p_q <= (div_quot > 40'd65535) ? 16'hFFFF : div_quot[15:0];
			prod_q <= 32'(div_quot > 40'd65535 ? 17'd65535 : {1'b0, div_quot[15:0]})
				* 32'(17'd65536 - (div_quot > 40'd65535 ? 17'd65535
				: {1'b0, div_quot[15:0]}));
		end
		if (state_q == ST_POUT && (!oval_q || out_ch.ready)) begin
			prob_q <= mode_q ? 16'((33'(prod_q) + 33'd32768) >> 16) : p_q;
			oidx_q <= 6'(i_q);
			olast_q <= (i_q + 1'b1 == cnt_q);
		end
	end

	assign out_ch.valid = oval_q;
	assign out_ch.prob_value = prob_q;
	assign out_ch.elem_index = oidx_q;
	assign out_ch.result_last = olast_q;
	assign out_ch.overflow_flag = drop_q_o;

	always_ff @(posedge clk)
		if (state_q == ST_POUT && (!oval_q || out_ch.ready)) drop_q_o <= drop_q;
endmodule

// ===== hdl/smx_chk.sv =====
// Port-level checker for softmax_normalizer_unit, bound into softmax_normalizer_unit.
// Depends on smx_if.
module smx_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid, out_ready, out_last,
	input logic [15:0] out_prob
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_prob))
		else $error("output word dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready mid vector output");
	// last word either already sits in the output register or is still pending
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid || !in_ready)
		else $error("input ready before last result");
endmodule

bind softmax_normalizer_unit smx_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.result_last),
	.out_prob(out_ch.prob_value)
);

// ===== sim/smx_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side notes for the channel interfaces: the interfaces themselves
// come from hdl/smx_if.sv; this file holds the scoreboard class. No dependencies.
class smx_scoreboard;
	typedef struct packed {
		logic [15:0] prob;
		logic [5:0] idx;
		logic last;
		logic ovf;
	} prob_word_t;

	logic signed [15:0] logits[$];
	logic signed [15:0] vec_max;
	bit lost;
	bit deriv;
	prob_word_t pending[$];
	int errors;
	int words_checked;
	int vectors;

	function new();
		logits.delete();
		vec_max = -16'sd32768;
		lost = 0;
		deriv = 0;
		errors = 0;
		words_checked = 0;
		vectors = 0;
	endfunction

	function logic [16:0] tab(input int k);
		logic [16:0] t[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
			46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
		return t[k];
	endfunction

	function logic [16:0] exp_of_gap(input logic [31:0] d);
		logic [31:0] t, n, f, k, r, v;
		t = (d * 32'd23637 + 32'd8192) >> 14;
		n = t >> 12;
		f = t & 32'hfff;
		k = f >> 8;
		r = f & 32'hff;
		v = tab(k) - (((tab(k) - tab(k + 1)) * r + 32'd128) >> 8);
		if (n == 0) return v[16:0];
		if (n > 16) return 17'd0;
		return 17'((v + (32'd1 << (n - 1))) >> n);
	endfunction

	function void note_sample(input logic signed [15:0] x, input logic is_last);
		logic [16:0] e[$];
		logic [22:0] sum;
		logic [63:0] p;
		prob_word_t w;
		if (logits.size() < 64) begin
			logits.push_back(x);
			if (x > vec_max) vec_max = x;
		end else
			lost = 1;
		if (!is_last) return;
		sum = 0;
		foreach (logits[i]) begin
			e.push_back(exp_of_gap(32'(int'(vec_max) - int'(logits[i]))));
			sum = sum + e[i];
		end
		foreach (e[i]) begin
			p = 0;
			if (sum != 0) begin
				p = ((64'(e[i]) << 16) + 64'(sum >> 1)) / 64'(sum);
				if (p > 65535) p = 65535;
			end
			if (deriv) p = (p * (64'd65536 - p) + 64'd32768) >> 16;
			w.prob = p[15:0];
			w.idx = 6'(i);
			w.last = (i == e.size() - 1);
			w.ovf = lost;
			pending.push_back(w);
		end
		vectors++;
		logits.delete();
		vec_max = -16'sd32768;
		lost = 0;
	endfunction

	function void check_word(input prob_word_t got);
		prob_word_t exp_w;
		words_checked++;
		if (pending.size() == 0) begin
			$error("unexpected output word prob=%0d idx=%0d", got.prob, got.idx);
			errors++;
			return;
		end
		exp_w = pending.pop_front();
		if (got.prob !== exp_w.prob) begin
			$error("prob_value expected %0d got %0d", exp_w.prob, got.prob); errors++;
		end
		if (got.idx !== exp_w.idx) begin
			$error("elem_index expected %0d got %0d", exp_w.idx, got.idx); errors++;
		end
		if (got.last !== exp_w.last) begin
			$error("result_last expected %0b got %0b", exp_w.last, got.last); errors++;
		end
		if (got.ovf !== exp_w.ovf) begin
			$error("overflow_flag expected %0b got %0b", exp_w.ovf, got.ovf); errors++;
		end
	endfunction
endclass

// ===== sim/tb_softmax_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Top testbench for softmax_normalizer_unit: drives vectors and the mode
// register, checks results through smx_scoreboard. Depends on hdl/smx_if.sv, sim/smx_tb_if.sv.
module tb_softmax_normalizer_unit;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	bit steady;
	int stall_cnt;
	int sent;
	smx_scoreboard board = new();

	smx_in_if in_ch();
	smx_out_if out_ch();
	smx_cfg_if cfg();

	softmax_normalizer_unit u_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg(cfg));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// sink side: random backpressure (none while steady), checks each word
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_word({out_ch.prob_value, out_ch.elem_index,
				out_ch.result_last, out_ch.overflow_flag});
		out_ch.ready <= arst_n && (steady || ($urandom_range(99) >= 34));
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= IDLE_LIMIT) begin
			$display("FAIL softmax_normalizer_unit");
			$finish;
		end
	end

	// valid stays up after a transfer; it drops only when the sender idles
	task automatic send_sample(input logic signed [15:0] x, input logic is_last);
		while (!steady && $urandom_range(99) < 34) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.sample_value <= x;
		in_ch.sample_last <= is_last;
		do @(posedge clk); while (!in_ch.ready);
		board.note_sample(x, is_last);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg.valid <= 1;
		cfg.data <= m;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		board.deriv = m;
	endtask

	task automatic send_vector(input int len, input int spread);
		for (int i = 0; i < len; i++)
			send_sample(16'($signed($urandom_range(2 * spread)) - spread), i == len - 1);
	endtask

	initial begin
		int len;
		in_ch.valid = 0;
		in_ch.sample_value = 0;
		in_ch.sample_last = 0;
		cfg.valid = 0;
		cfg.data = 0;
		sent = 0;
		steady = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: single element, extremes, equal values, full and overfull store
		send_sample(16'sh7fff, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd4096, 1'b0);
		send_sample(-16'sd4096, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(-16'sh5556, 1'b1);
		set_mode(1'b1);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd100, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_vector(64, 32768);
		send_vector(70, 20000);
		set_mode(1'b0);
		// sender holds off until everything is back
		drain();
		steady = 1;
		send_vector(66, 6000);
		send_vector(8, 32768);
		steady = 0;
		while (sent < 310) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 68) : $urandom_range(1, 10);
			send_vector(len, ($urandom_range(1) != 0) ? 32768 : $urandom_range(16000));
			if ($urandom_range(7) == 0) set_mode(1'($urandom_range(1)));
		end
		set_mode(1'b1);
		send_vector(5, 32768);
		set_mode(1'b0);
		$display("Covered %0d logits in %0d vectors, %0d result words checked,",
			sent, board.vectors, board.words_checked);
		$display("both modes, full and overfull stores, random stalls on both sides.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS softmax_normalizer_unit");
		else
			$display("FAIL softmax_normalizer_unit");
		$finish;
	end
endmodule
